[sv/weo_pkg.sv]
package weo_pkg;

    localparam int DIST_W      = 30;
    localparam int DPC_W       = 21;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_IDX_W   = 3;
    localparam int REG_W       = 16;
    localparam int NUM_WHEELS  = 6;
    localparam int DIST_LIMIT  = 268435456;

    // wheel order in every array
    localparam int W_FL = 0;
    localparam int W_FR = 1;
    localparam int W_BL = 2;
    localparam int W_BR = 3;
    localparam int W_ML = 4;
    localparam int W_MR = 5;

    localparam logic [REG_W-1:0] RST_MAX_COUNT  = 16'd61566;
    localparam logic [REG_W-1:0] RST_IMPLAUS    = 16'd10000;
    localparam logic [REG_W-1:0] RST_SPIKE      = 16'd1000;
    localparam logic [DPC_W-1:0] RST_DPC        = 21'd0;
    localparam logic             RST_SIX_WHEEL  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_COUNT = 3'd0,
        CFG_IMPLAUS   = 3'd1,
        CFG_SPIKE     = 3'd2,
        CFG_DPC       = 3'd3,
        CFG_SIX_WHEEL = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [REG_W-1:0] wrap_top;
        logic [REG_W-1:0] implausible_step;
        logic [REG_W-1:0] spike_limit;
        logic [DPC_W-1:0] distance_per_count;
        logic             six_wheel_mode;
    } t_cfg;

    typedef logic signed [DIST_W-1:0] t_dist;

endpackage

[sv/weo_cfg.sv]
module weo_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [weo_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [weo_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output weo_pkg::t_cfg                    o_cfg
);

    weo_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_top           <= weo_pkg::RST_MAX_COUNT;
            r_cfg.implausible_step   <= weo_pkg::RST_IMPLAUS;
            r_cfg.spike_limit        <= weo_pkg::RST_SPIKE;
            r_cfg.distance_per_count <= weo_pkg::RST_DPC;
            r_cfg.six_wheel_mode     <= weo_pkg::RST_SIX_WHEEL;
        end else if (i_cfg_we) begin
            case (weo_pkg::t_cfg_idx'(i_cfg_idx))
                weo_pkg::CFG_MAX_COUNT: begin
                    r_cfg.wrap_top <= i_cfg_data[weo_pkg::REG_W-1:0];
                end
                weo_pkg::CFG_IMPLAUS: begin
                    r_cfg.implausible_step <= i_cfg_data[weo_pkg::REG_W-1:0];
                end
                weo_pkg::CFG_SPIKE: begin
                    r_cfg.spike_limit <= i_cfg_data[weo_pkg::REG_W-1:0];
                end
                weo_pkg::CFG_DPC: begin
                    r_cfg.distance_per_count <= i_cfg_data[weo_pkg::DPC_W-1:0];
                end
                weo_pkg::CFG_SIX_WHEEL: begin
                    r_cfg.six_wheel_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/weo_wheel.sv]
module weo_wheel #(
    parameter int COUNT_WIDTH = 16,
    parameter int SCALE_SHIFT = 8
) (
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic [COUNT_WIDTH-1:0] i_prev,
    input  logic                   i_fresh,
    input  weo_pkg::t_cfg          i_cfg,
    output weo_pkg::t_dist         o_dist
);

    // step arithmetic wide enough for count, register and wrap sums
    localparam int BW = ((COUNT_WIDTH > weo_pkg::REG_W) ? COUNT_WIDTH : weo_pkg::REG_W) + 3;
    localparam int PW = BW + weo_pkg::DPC_W + 1;
    localparam logic signed [PW-1:0] LIM_HI = PW'(weo_pkg::DIST_LIMIT);
    localparam logic signed [PW-1:0] LIM_LO = -LIM_HI;

    logic signed [BW-1:0]            now_s;
    logic signed [BW-1:0]            prev_s;
    logic signed [BW-1:0]            top_s;
    logic signed [BW-1:0]            half_s;
    logic signed [BW-1:0]            imp_s;
    logic signed [BW-1:0]            spk_s;
    logic signed [BW-1:0]            raw_step;
    logic signed [BW-1:0]            wrap_step;
    logic signed [BW-1:0]            raw_mag;
    logic signed [BW-1:0]            wrap_mag;
    logic signed [BW-1:0]            step;
    logic signed [weo_pkg::DPC_W:0]  dpc_s;
    logic signed [PW-1:0]            prod;
    logic signed [PW-1:0]            scaled;
    logic signed [PW-1:0]            clamped;

    always_comb begin
        now_s    = $signed(BW'(i_count));
        prev_s   = $signed(BW'(i_prev));
        top_s    = $signed(BW'(i_cfg.wrap_top));
        half_s   = $signed(BW'(i_cfg.wrap_top >> 1));
        imp_s    = $signed(BW'(i_cfg.implausible_step));
        spk_s    = $signed(BW'(i_cfg.spike_limit));

        raw_step = now_s - prev_s;
        // wrap direction follows which half of the range the old count sat in
        if (prev_s > half_s) begin
            wrap_step = (top_s - prev_s) + now_s;
        end else begin
            wrap_step = -prev_s - (top_s - now_s);
        end
        raw_mag  = raw_step[BW-1]  ? -raw_step  : raw_step;
        wrap_mag = wrap_step[BW-1] ? -wrap_step : wrap_step;

        if (raw_mag > imp_s) begin
            step = (wrap_mag > spk_s) ? '0 : wrap_step;
        end else begin
            step = raw_step;
        end

        dpc_s   = $signed({1'b0, i_cfg.distance_per_count});
        prod    = PW'(step) * PW'(dpc_s);
        scaled  = prod >>> SCALE_SHIFT;

        if (scaled > LIM_HI) begin
            clamped = LIM_HI;
        end else if (scaled < LIM_LO) begin
            clamped = LIM_LO;
        end else begin
            clamped = scaled;
        end

        o_dist = i_fresh ? $signed(clamped[weo_pkg::DIST_W-1:0]) : '0;
    end

endmodule

[sv/weo_fuse.sv]
module weo_fuse (
    input  weo_pkg::t_dist i_dist [weo_pkg::NUM_WHEELS],
    input  logic           i_six_wheel,
    input  logic           i_hold,
    output weo_pkg::t_dist o_delta
);

    localparam int DW = weo_pkg::DIST_W;

    function automatic weo_pkg::t_dist med3(weo_pkg::t_dist a, weo_pkg::t_dist b,
                                            weo_pkg::t_dist c);
        weo_pkg::t_dist lo;
        weo_pkg::t_dist hi;
        weo_pkg::t_dist mid;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        mid = (hi < c) ? hi : c;
        return (lo > mid) ? lo : mid;
    endfunction

    weo_pkg::t_dist           med_l;
    weo_pkg::t_dist           med_r;
    logic signed [DW:0]       six_sum;
    logic signed [DW+1:0]     four_sum;
    logic signed [DW:0]       six_half;
    logic signed [DW+1:0]     four_avg;

    always_comb begin
        med_l    = med3(i_dist[weo_pkg::W_ML], i_dist[weo_pkg::W_FL], i_dist[weo_pkg::W_BL]);
        med_r    = med3(i_dist[weo_pkg::W_MR], i_dist[weo_pkg::W_FR], i_dist[weo_pkg::W_BR]);
        six_sum  = (DW+1)'(med_l) + (DW+1)'(med_r);
        four_sum = (DW+2)'(i_dist[weo_pkg::W_FL]) + (DW+2)'(i_dist[weo_pkg::W_BL])
                 + (DW+2)'(i_dist[weo_pkg::W_FR]) + (DW+2)'(i_dist[weo_pkg::W_BR]);
        six_half = six_sum >>> 1;
        four_avg = four_sum >>> 2;
        // both forms stay inside the wheel distance limits
        if (i_hold) begin
            o_delta = '0;
        end else if (i_six_wheel) begin
            o_delta = $signed(six_half[DW-1:0]);
        end else begin
            o_delta = $signed(four_avg[DW-1:0]);
        end
    end

endmodule

[sv/wheel_encoder_odometry_core.sv]
// An accepted item is loaded into the input register, then moves into the result
// register once that register can take it, and the result is offered from there.
// Throughput: one item per cycle; the result register frees the input side
// even while a result waits, and only a full pipe under a stalled result stops intake.
// Reset (i_rst_n low, synchronous): both stages empty, stored counts zero,
// configuration back to its defaults.
module wheel_encoder_odometry_core #(
    parameter int COUNT_WIDTH = 16,
    parameter int SCALE_SHIFT = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [weo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [weo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input item channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [COUNT_WIDTH-1:0]         i_count_front_left,
    input  logic [COUNT_WIDTH-1:0]         i_count_front_right,
    input  logic [COUNT_WIDTH-1:0]         i_count_back_left,
    input  logic [COUNT_WIDTH-1:0]         i_count_back_right,
    input  logic [COUNT_WIDTH-1:0]         i_count_mid_left,
    input  logic [COUNT_WIDTH-1:0]         i_count_mid_right,
    input  logic                           i_left_fresh,
    input  logic                           i_right_fresh,
    input  logic                           i_turning,
    input  logic                           i_stopped,
    // result item channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [weo_pkg::DIST_W-1:0] o_dist_front_left,
    output logic signed [weo_pkg::DIST_W-1:0] o_dist_front_right,
    output logic signed [weo_pkg::DIST_W-1:0] o_dist_back_left,
    output logic signed [weo_pkg::DIST_W-1:0] o_dist_back_right,
    output logic signed [weo_pkg::DIST_W-1:0] o_dist_mid_left,
    output logic signed [weo_pkg::DIST_W-1:0] o_dist_mid_right,
    output logic signed [weo_pkg::DIST_W-1:0] o_fwd_travel
);

    localparam int NW = weo_pkg::NUM_WHEELS;

    weo_pkg::t_cfg           cfg;

    // input stage
    logic                    r_in_valid;
    logic [COUNT_WIDTH-1:0]  r_count [NW];
    logic                    r_left_fresh;
    logic                    r_right_fresh;
    logic                    r_hold;

    // stored counts, one per wheel, order FL FR BL BR ML MR
    logic [COUNT_WIDTH-1:0]  r_prev [NW];

    // result stage
    logic                    r_out_valid;
    weo_pkg::t_dist          r_dist [NW];
    weo_pkg::t_dist          r_delta;

    weo_pkg::t_dist          n_dist [NW];
    weo_pkg::t_dist          n_delta;
    logic                    wheel_fresh [NW];

    logic                    adv;      // result register can take the input stage
    logic                    in_acc;
    logic                    move;     // an item passes from input to result stage

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign move       = r_in_valid && adv;

    weo_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_count[weo_pkg::W_FL] <= i_count_front_left;
            r_count[weo_pkg::W_FR] <= i_count_front_right;
            r_count[weo_pkg::W_BL] <= i_count_back_left;
            r_count[weo_pkg::W_BR] <= i_count_back_right;
            r_count[weo_pkg::W_ML] <= i_count_mid_left;
            r_count[weo_pkg::W_MR] <= i_count_mid_right;
            r_left_fresh           <= i_left_fresh;
            r_right_fresh          <= i_right_fresh;
            r_hold                 <= i_turning || i_stopped;
        end
    end

    // per-wheel step, wrap/spike handling and scaling; even indices are left side
    for (genvar w = 0; w < NW; w++) begin : g_wheel
        assign wheel_fresh[w] = ((w % 2) == 0) ? r_left_fresh : r_right_fresh;

        weo_wheel #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .SCALE_SHIFT (SCALE_SHIFT)
        ) u_wheel (
            .i_count (r_count[w]),
            .i_prev  (r_prev[w]),
            .i_fresh (wheel_fresh[w]),
            .i_cfg   (cfg),
            .o_dist  (n_dist[w])
        );

        // stale side keeps its old count
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_prev[w] <= '0;
            end else if (move && wheel_fresh[w]) begin
                r_prev[w] <= r_count[w];
            end
        end
    end

    weo_fuse u_fuse (
        .i_dist      (n_dist),
        .i_six_wheel (cfg.six_wheel_mode),
        .i_hold      (r_hold),
        .o_delta     (n_delta)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_dist  <= n_dist;
            r_delta <= n_delta;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_dist_front_left  = r_dist[weo_pkg::W_FL];
    assign o_dist_front_right = r_dist[weo_pkg::W_FR];
    assign o_dist_back_left   = r_dist[weo_pkg::W_BL];
    assign o_dist_back_right  = r_dist[weo_pkg::W_BR];
    assign o_dist_mid_left    = r_dist[weo_pkg::W_ML];
    assign o_dist_mid_right   = r_dist[weo_pkg::W_MR];
    assign o_fwd_travel       = r_delta;

endmodule

[sv/weo_checker.sv]
module weo_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [weo_pkg::DIST_W-1:0] o_dist_front_left,
    input  logic signed [weo_pkg::DIST_W-1:0] o_dist_front_right,
    input  logic signed [weo_pkg::DIST_W-1:0] o_dist_back_left,
    input  logic signed [weo_pkg::DIST_W-1:0] o_dist_back_right,
    input  logic signed [weo_pkg::DIST_W-1:0] o_dist_mid_left,
    input  logic signed [weo_pkg::DIST_W-1:0] o_dist_mid_right,
    input  logic signed [weo_pkg::DIST_W-1:0] o_fwd_travel
);

    localparam int DW = weo_pkg::DIST_W;
    localparam logic signed [DW-1:0] LIM = DW'(weo_pkg::DIST_LIMIT);

    logic all_zero;
    assign all_zero = (o_dist_front_left == '0) && (o_dist_front_right == '0)
                   && (o_dist_back_left == '0) && (o_dist_back_right == '0)
                   && (o_dist_mid_left == '0) && (o_dist_mid_right == '0);

    // a result is never produced straight out of reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // intake stops only when the result side is full and stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("intake stalled without a stalled result");

    // a stalled result holds its fused value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_fwd_travel)))
        else $error("stalled result changed");

    // no wheel travel means no fused travel
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && all_zero) |-> (o_fwd_travel == '0))
        else $error("fused travel without wheel travel");

    // fused travel stays within the distance limits
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_fwd_travel <= LIM) && (o_fwd_travel >= -LIM)))
        else $error("fused travel out of range");

endmodule

bind wheel_encoder_odometry_core weo_checker u_weo_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_dist_front_left  (o_dist_front_left),
    .o_dist_front_right (o_dist_front_right),
    .o_dist_back_left   (o_dist_back_left),
    .o_dist_back_right  (o_dist_back_right),
    .o_dist_mid_left    (o_dist_mid_left),
    .o_dist_mid_right   (o_dist_mid_right),
    .o_fwd_travel       (o_fwd_travel)
);
